// ===== hw/rtl/erm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erm_pkg
// Widths, constants and codes shared by the echo range median filter.
// ----------------------------------------------------------------------------
package erm_pkg;

   localparam int WIN_LEN    = 5;
   localparam int CNT_W      = $clog2(WIN_LEN + 1);
   localparam int PULSE_W    = 15;
   localparam int DIST_W     = 13;
   localparam int STAMP_W    = 32;
   localparam int HOLD_W     = 16;
   localparam int STATUS_W   = 2;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;
   localparam int SCALE_W    = 14;
   localparam int PROD_W     = PULSE_W + SCALE_W;
   localparam int FRAC_W     = 16;

   // half the speed of sound in mm/us, unsigned Q0.16
   localparam logic [SCALE_W-1:0] SOUND_HALF_Q16 = 14'd11239;

   localparam logic [DIST_W-1:0] MAX_DIST_RESET = 13'd4000;
   localparam logic [HOLD_W-1:0] HOLD_RESET     = 16'd500;

   localparam logic [CSR_IDX_W-1:0] CSR_MAX_DIST = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLD     = 1'd1;

   typedef logic [DIST_W-1:0] dist_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_FRESH = 2'd0,
      ST_HELD  = 2'd1,
      ST_NONE  = 2'd2
   } status_type;

endpackage

// ===== hw/rtl/erm_ifs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erm channel interfaces
// Valid/ready channels for echo measurement items and filtered results.
// ----------------------------------------------------------------------------
interface erm_req_if import erm_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [PULSE_W-1:0] pulse_width;
   logic               echo_seen;
   logic [STAMP_W-1:0] now_ms;

   modport source (output valid, pulse_width, echo_seen, now_ms, input ready);
   modport sink   (input valid, pulse_width, echo_seen, now_ms, output ready);
endinterface

interface erm_rsp_if import erm_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [DIST_W-1:0]   range_mm;
   logic [STATUS_W-1:0] status;

   modport source (output valid, range_mm, status, input ready);
   modport sink   (input valid, range_mm, status, output ready);
endinterface

// ===== hw/rtl/erm_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erm_cell
// One window slot: takes its neighbour's value whenever a new item is pushed.
// ----------------------------------------------------------------------------
module erm_cell import erm_pkg::*; (
   input  logic     clock,
   input  logic     shift_en,
   input  dist_type d_in,
   output dist_type q
);

   dist_type value_ff;
   dist_type value_in;

   always_comb begin
      value_in = shift_en ? d_in : value_ff;
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign q = value_ff;

endmodule

// ===== hw/rtl/erm_rank.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erm_rank
// Picks the element of a given sorted position by parallel rank compare.
// ----------------------------------------------------------------------------
module erm_rank import erm_pkg::*; (
   input  dist_type             cand [WIN_LEN],
   input  logic [WIN_LEN-1:0]   cand_valid,
   input  logic [CNT_W-1:0]     pick,
   output dist_type             median
);

   logic [CNT_W-1:0] rank [WIN_LEN];

   // ties broken by position so that every valid element has its own rank
   always_comb begin
      for (int i = 0; i < WIN_LEN; i++) begin
         rank[i] = '0;
         for (int j = 0; j < WIN_LEN; j++) begin
            if (cand_valid[j] && ((cand[j] < cand[i]) ||
                                  ((j < i) && (cand[j] == cand[i])))) begin
               rank[i] = rank[i] + 1'b1;
            end
         end
      end
   end

   always_comb begin
      median = '0;
      for (int i = 0; i < WIN_LEN; i++) begin
         if (cand_valid[i] && (rank[i] == pick)) begin
            median = median | cand[i];
         end
      end
   end

endmodule

// ===== hw/rtl/echo_range_median_hold_filter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// echo_range_median_hold_filter
// Range conversion, five-deep running median and hold of the last good value.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one echo measurement per item (pulse_width, echo_seen, now_ms);
//   rsp returns one item per request (range_mm, status) in order.
//   csr_we/csr_index/csr_wdata write the distance limit (index 0) and hold_ms
//   (index 1); write them only while no item is in flight.
// Pipeline: a request passes the stage one registers, then the result register:
//   stage one scales the pulse width by a single 15x14 multiply and clamps,
//   stage two updates the cell chain, ranks the window and picks the median.
// Throughput: one item per cycle unless rsp stalls; the window chain shifts
//   one cell per nonzero item and the rank compare over all cells is combinational.
// Reset: window emptied, held value and stamp cleared, registers back to
//   4000 mm and 500 ms; no clearing pass is needed.
// Stall: while a result waits on rsp, the whole pipeline holds and req.ready
//   drops; it rises again in the cycle the result is taken.
// ----------------------------------------------------------------------------
module echo_range_median_hold_filter import erm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   erm_req_if.sink               req,
   erm_rsp_if.source             rsp,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // configuration
   dist_type          max_dist_ff, max_dist_in;
   logic [HOLD_W-1:0] hold_ff, hold_in;

   // stage one
   logic               s1_valid_ff, s1_valid_in;
   dist_type           s1_raw_ff, s1_raw_in;
   logic [STAMP_W-1:0] s1_now_ff, s1_now_in;
   logic [PROD_W-1:0]  prod;
   dist_type           scaled;

   // filter state
   logic [CNT_W-1:0]   count_ff, count_in;
   dist_type           last_good_ff, last_good_in;
   logic [STAMP_W-1:0] stamp_ff, stamp_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   dist_type           rsp_dist_ff, rsp_dist_in;
   status_type         rsp_status_ff, rsp_status_in;

   logic               advance;
   logic               push;
   logic               hold_ok;
   logic [STAMP_W-1:0] age;
   logic [CNT_W-1:0]   new_count;
   logic [WIN_LEN-1:0] cand_valid;
   dist_type           cand [WIN_LEN];
   dist_type           median;

   assign advance   = !rsp_valid_ff || rsp.ready;
   assign req.ready = advance;

   always_comb begin
      max_dist_in = max_dist_ff;
      hold_in     = hold_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_MAX_DIST: max_dist_in = csr_wdata[DIST_W-1:0];
            CSR_HOLD:     hold_in     = csr_wdata[HOLD_W-1:0];
            default:      ;
         endcase
      end
   end

   // stage one: scale and clamp
   always_comb begin
      prod   = PROD_W'(req.pulse_width) * PROD_W'(SOUND_HALF_Q16);
      scaled = prod[FRAC_W +: DIST_W];
      if (!req.echo_seen) begin
         s1_raw_in = '0;
      end else if (scaled > max_dist_ff) begin
         s1_raw_in = max_dist_ff;
      end else begin
         s1_raw_in = scaled;
      end
      s1_valid_in = advance ? req.valid : s1_valid_ff;
      s1_now_in   = req.now_ms;
   end

   // stage two: window chain and median pick
   assign push  = s1_valid_ff && (s1_raw_ff != '0);
   assign cand[0] = s1_raw_ff;

   for (genvar k = 1; k < WIN_LEN; k++) begin : g_chain
      erm_cell u_cell (
         .clock    (clock),
         .shift_en (advance && push),
         .d_in     (cand[k-1]),
         .q        (cand[k])
      );
   end

   always_comb begin
      for (int k = 0; k < WIN_LEN; k++) begin
         cand_valid[k] = (k == 0) || (CNT_W'(k) <= count_ff);
      end
      new_count = (count_ff < CNT_W'(WIN_LEN)) ? count_ff + 1'b1 : CNT_W'(WIN_LEN);
   end

   erm_rank u_rank (
      .cand       (cand),
      .cand_valid (cand_valid),
      .pick       (new_count >> 1),
      .median     (median)
   );

   assign age     = s1_now_ff - stamp_ff;
   assign hold_ok = (last_good_ff != '0) && (age <= STAMP_W'(hold_ff));

   always_comb begin
      count_in      = count_ff;
      last_good_in  = last_good_ff;
      stamp_in      = stamp_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_dist_in   = rsp_dist_ff;
      rsp_status_in = rsp_status_ff;
      if (advance) begin
         rsp_valid_in = s1_valid_ff;
         if (s1_valid_ff) begin
            priority if (push) begin
               count_in      = new_count;
               last_good_in  = median;
               stamp_in      = s1_now_ff;
               rsp_dist_in   = median;
               rsp_status_in = ST_FRESH;
            end else if (hold_ok) begin
               rsp_dist_in   = last_good_ff;
               rsp_status_in = ST_HELD;
            end else begin
               // drop the window and the held value
               count_in      = '0;
               last_good_in  = '0;
               rsp_dist_in   = '0;
               rsp_status_in = ST_NONE;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_dist_ff  <= MAX_DIST_RESET;
         hold_ff      <= HOLD_RESET;
         s1_valid_ff  <= 1'b0;
         count_ff     <= '0;
         last_good_ff <= '0;
         stamp_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         max_dist_ff  <= max_dist_in;
         hold_ff      <= hold_in;
         s1_valid_ff  <= s1_valid_in;
         count_ff     <= count_in;
         last_good_ff <= last_good_in;
         stamp_ff     <= stamp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_raw_ff <= s1_raw_in;
         s1_now_ff <= s1_now_in;
      end
      rsp_dist_ff   <= rsp_dist_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.range_mm = rsp_dist_ff;
   assign rsp.status   = rsp_status_ff;

   // assertions
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(WIN_LEN))
      else $error("window count beyond window length");

   a_fresh_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff == ST_FRESH) |-> rsp_dist_ff != '0)
      else $error("fresh median of zero");

   a_held_matches: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff == ST_HELD) |-> rsp_dist_ff == last_good_ff)
      else $error("held result differs from held value");

   a_none_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff == ST_NONE) |->
         (count_ff == '0) && (last_good_ff == '0) && (rsp_dist_ff == '0))
      else $error("cleared result with state left behind");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp.ready |=> rsp_valid_ff && $stable(count_ff)
         && $stable(last_good_ff))
      else $error("state moved while the result stalled");

endmodule
